// ===== sv/rv64_instruction_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// rv64 decoder assertion macros
// shared property shorthands for the decoder checker
// ----------------------------------------------------------------------------
`ifndef RV64_INSTRUCTION_DECODER_CORE_MACROS_SVH
`define RV64_INSTRUCTION_DECODER_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define RDEC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rdec check failed");

// next-cycle implication outside reset
`define RDEC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rdec check failed");

`endif

// ===== sv/rdec_pkg.sv =====
// ----------------------------------------------------------------------------
// rdec_pkg
// shared types and constants of the rv64 instruction decoder
// ----------------------------------------------------------------------------
package rdec_pkg;

    localparam int InWidth  = 32;
    localparam int OutWidth = 104;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OPIMMW = 7'h1B;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPW    = 7'h3B;
    localparam logic [6:0] OPC_AMO    = 7'h2F;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [31:0] W_ECALL   = 32'h0000_0073;
    localparam logic [31:0] W_EBREAK  = 32'h0010_0073;
    localparam logic [31:0] W_MRET    = 32'h3020_0073;
    localparam logic [31:0] W_SRET    = 32'h1020_0073;
    localparam logic [31:0] W_WFI     = 32'h1050_0073;
    localparam logic [31:0] SFV_MASK  = 32'hFE00_7FFF;
    localparam logic [31:0] SFV_MATCH = 32'h1200_0073;

    localparam logic [6:0] K_ILLEGAL = 7'd0;
    localparam logic [6:0] K_LUI     = 7'd1;
    localparam logic [6:0] K_AUIPC   = 7'd2;
    localparam logic [6:0] K_JAL     = 7'd3;
    localparam logic [6:0] K_JALR    = 7'd4;
    localparam logic [6:0] K_LOAD0   = 7'd11;
    localparam logic [6:0] K_STORE0  = 7'd18;
    localparam logic [6:0] K_SLLI    = 7'd28;
    localparam logic [6:0] K_SRLI    = 7'd29;
    localparam logic [6:0] K_SRAI    = 7'd30;
    localparam logic [6:0] K_ADDIW   = 7'd31;
    localparam logic [6:0] K_SLLIW   = 7'd32;
    localparam logic [6:0] K_SRLIW   = 7'd33;
    localparam logic [6:0] K_SRAIW   = 7'd34;
    localparam logic [6:0] K_ADD0    = 7'd35;
    localparam logic [6:0] K_SUB     = 7'd43;
    localparam logic [6:0] K_SRA     = 7'd44;
    localparam logic [6:0] K_MUL0    = 7'd45;
    localparam logic [6:0] K_SUBW    = 7'd56;
    localparam logic [6:0] K_SRAW    = 7'd57;
    localparam logic [6:0] K_AMO0    = 7'd63;
    localparam logic [6:0] K_FENCE   = 7'd85;
    localparam logic [6:0] K_FENCEI  = 7'd86;
    localparam logic [6:0] K_ECALL   = 7'd87;
    localparam logic [6:0] K_EBREAK  = 7'd88;
    localparam logic [6:0] K_MRET    = 7'd89;
    localparam logic [6:0] K_SRET    = 7'd90;
    localparam logic [6:0] K_WFI     = 7'd91;
    localparam logic [6:0] K_SFENCE  = 7'd92;
    localparam logic [6:0] K_CSR0    = 7'd93;
    localparam logic [6:0] K_MAX     = 7'd98;

    typedef struct packed {
        logic        release_flag;
        logic        acquire_flag;
        logic [11:0] csr_number;
        logic [63:0] imm_value;
        logic [4:0]  src2_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  dest_reg;
        logic [6:0]  op_kind;
    } dec_out_t;

    function automatic logic [6:0] branch_kind(input logic [2:0] f3);
        logic [6:0] k;
        unique case (f3)
            3'd0: k = 7'd5;
            3'd1: k = 7'd6;
            3'd4: k = 7'd7;
            3'd5: k = 7'd8;
            3'd6: k = 7'd9;
            3'd7: k = 7'd10;
            default: k = K_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] opimm_kind(input logic [2:0] f3);
        logic [6:0] k;
        unique case (f3)
            3'd0: k = 7'd22;
            3'd2: k = 7'd23;
            3'd3: k = 7'd24;
            3'd4: k = 7'd25;
            3'd6: k = 7'd26;
            3'd7: k = 7'd27;
            default: k = K_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] opw_kind(input logic [2:0] f3);
        logic [6:0] k;
        unique case (f3)
            3'd0: k = 7'd53;
            3'd1: k = 7'd54;
            3'd5: k = 7'd55;
            default: k = K_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] mulw_kind(input logic [2:0] f3);
        logic [6:0] k;
        unique case (f3)
            3'd0: k = 7'd58;
            3'd4: k = 7'd59;
            3'd5: k = 7'd60;
            3'd6: k = 7'd61;
            3'd7: k = 7'd62;
            default: k = K_ILLEGAL;
        endcase
        return k;
    endfunction

    // pair index plus one, zero when the funct5 is unused
    function automatic logic [3:0] amo_slot(input logic [4:0] f5);
        logic [3:0] s;
        unique case (f5)
            5'd0:  s = 4'd4;
            5'd1:  s = 4'd3;
            5'd2:  s = 4'd1;
            5'd3:  s = 4'd2;
            5'd4:  s = 4'd5;
            5'd8:  s = 4'd7;
            5'd12: s = 4'd6;
            5'd16: s = 4'd8;
            5'd20: s = 4'd9;
            5'd24: s = 4'd10;
            5'd28: s = 4'd11;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/rv64_instruction_decoder_core.sv =====
// ----------------------------------------------------------------------------
// rv64_instruction_decoder_core
// rv64ima instruction decoder with stream handshakes
// ----------------------------------------------------------------------------
// Takes one 32-bit instruction beat per cycle while m_tready allows and
// returns one decoded beat. The word is held in an input register, decoded
// by a single combinational pass and captured in the result register, from
// which it drives the result port, so the block sustains one beat per cycle
// while m_tready is high; each of the two register stages refills in the
// same cycle its content is taken.
module rv64_instruction_decoder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rdec_pkg::InWidth-1:0]  s_tdata,  // instruction_word
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // op_kind, dest_reg, src1_reg, src2_reg, imm_value, csr_number,
    // acquire_flag, release_flag
    output logic [rdec_pkg::OutWidth-1:0] m_tdata
);
    import rdec_pkg::*;

    logic        in_vld_reg;
    logic [31:0] in_word_reg;
    logic        out_vld_reg;
    dec_out_t    out_reg;
    dec_out_t    dec;
    logic        out_free, in_free;

    assign out_free = !out_vld_reg || m_tready;
    assign in_free  = !in_vld_reg || out_free;
    assign s_tready = in_free;

    rdec_logic u_logic (
        .instr (in_word_reg),
        .dec   (dec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_free) in_vld_reg <= s_tvalid;
            if (out_free) out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_free && s_tvalid) in_word_reg <= s_tdata;
        if (out_free && in_vld_reg) out_reg <= dec;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, out_reg};

endmodule

// ===== sv/rdec_logic.sv =====
// ----------------------------------------------------------------------------
// rdec_logic
// combinational decode of one instruction word into its result fields
// ----------------------------------------------------------------------------
module rdec_logic (
    input  logic [31:0]        instr,
    output rdec_pkg::dec_out_t dec
);
    import rdec_pkg::*;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [63:0] ii, si, bi, ui, ji, sh6, sh5, uimm;
    logic [3:0]  slot;
    logic [6:0]  kind;
    logic [63:0] imm;
    logic [11:0] csr;
    logic        aq, rl;

    assign opc  = instr[6:0];
    assign f3   = instr[14:12];
    assign f7   = instr[31:25];
    assign ii   = {{52{instr[31]}}, instr[31:20]};
    assign si   = {{52{instr[31]}}, instr[31:25], instr[11:7]};
    assign bi   = {{52{instr[31]}}, instr[7], instr[30:25], instr[11:8], 1'b0};
    assign ui   = {{32{instr[31]}}, instr[31:12], 12'd0};
    assign ji   = {{44{instr[31]}}, instr[19:12], instr[20], instr[30:21], 1'b0};
    assign sh6  = {58'd0, instr[25:20]};
    assign sh5  = {59'd0, instr[24:20]};
    assign uimm = {59'd0, instr[19:15]};
    assign slot = amo_slot(instr[31:27]);

    always_comb begin
        kind = K_ILLEGAL;
        imm  = '0;
        csr  = '0;
        aq   = 1'b0;
        rl   = 1'b0;
        unique case (opc)
            OPC_LUI: begin
                kind = K_LUI; imm = ui;
            end
            OPC_AUIPC: begin
                kind = K_AUIPC; imm = ui;
            end
            OPC_JAL: begin
                kind = K_JAL; imm = ji;
            end
            OPC_JALR: begin
                if (f3 == 3'd0) begin
                    kind = K_JALR; imm = ii;
                end
            end
            OPC_BRANCH: begin
                kind = branch_kind(f3); imm = bi;
            end
            OPC_LOAD: begin
                kind = (f3 != 3'd7) ? K_LOAD0 + {4'd0, f3} : K_ILLEGAL;
                imm  = ii;
            end
            OPC_STORE: begin
                kind = (f3[2] == 1'b0) ? K_STORE0 + {4'd0, f3} : K_ILLEGAL;
                imm  = si;
            end
            OPC_OPIMM: begin
                if (f3 == 3'd1) begin
                    if (instr[31:26] == 6'd0) begin
                        kind = K_SLLI; imm = sh6;
                    end
                end else if (f3 == 3'd5) begin
                    if (instr[31:26] == 6'd0) begin
                        kind = K_SRLI; imm = sh6;
                    end else if (instr[31:26] == 6'h10) begin
                        kind = K_SRAI; imm = sh6;
                    end
                end else begin
                    kind = opimm_kind(f3); imm = ii;
                end
            end
            OPC_OPIMMW: begin
                if (f3 == 3'd0) begin
                    kind = K_ADDIW; imm = ii;
                end else if (f3 == 3'd1 && f7 == 7'd0) begin
                    kind = K_SLLIW; imm = sh5;
                end else if (f3 == 3'd5 && f7 == 7'd0) begin
                    kind = K_SRLIW; imm = sh5;
                end else if (f3 == 3'd5 && f7 == 7'h20) begin
                    kind = K_SRAIW; imm = sh5;
                end
            end
            OPC_OP: begin
                if (f7 == 7'd0) kind = K_ADD0 + {4'd0, f3};
                else if (f7 == 7'h20)
                    kind = (f3 == 3'd0) ? K_SUB : (f3 == 3'd5) ? K_SRA : K_ILLEGAL;
                else if (f7 == 7'd1) kind = K_MUL0 + {4'd0, f3};
            end
            OPC_OPW: begin
                if (f7 == 7'd0) kind = opw_kind(f3);
                else if (f7 == 7'h20)
                    kind = (f3 == 3'd0) ? K_SUBW : (f3 == 3'd5) ? K_SRAW : K_ILLEGAL;
                else if (f7 == 7'd1) kind = mulw_kind(f3);
            end
            OPC_AMO: begin
                if (f3 == 3'd2 || f3 == 3'd3) begin
                    if (slot != 4'd0)
                        kind = K_AMO0 + {2'd0, slot - 4'd1, 1'b0} + {6'd0, f3[0]};
                    if (slot == 4'd1 && instr[24:20] != 5'd0) begin
                        kind = K_ILLEGAL;
                    end else begin
                        aq = instr[26];
                        rl = instr[25];
                    end
                end
            end
            OPC_FENCE: begin
                if (f3 == 3'd0) kind = K_FENCE;
                else if (f3 == 3'd1 && instr[31:15] == 17'd0 && instr[11:7] == 5'd0)
                    kind = K_FENCEI;
            end
            OPC_SYSTEM: begin
                if (instr == W_ECALL) kind = K_ECALL;
                else if (instr == W_EBREAK) kind = K_EBREAK;
                else if (instr == W_MRET) kind = K_MRET;
                else if (instr == W_SRET) kind = K_SRET;
                else if (instr == W_WFI) kind = K_WFI;
                else if ((instr & SFV_MASK) == SFV_MATCH) kind = K_SFENCE;
                else if (f3 != 3'd0 && f3 != 3'd4) begin
                    kind = (f3[2] == 1'b0) ? K_CSR0 + {4'd0, f3} - 7'd1
                                           : K_CSR0 + {4'd0, f3} - 7'd2;
                    csr  = instr[31:20];
                    if (f3[2]) imm = uimm;
                end
            end
            default: begin
                kind = K_ILLEGAL;
            end
        endcase
        if (kind == K_ILLEGAL && opc != OPC_BRANCH && opc != OPC_LOAD && opc != OPC_STORE)
            imm = '0;
    end

    assign dec.op_kind      = kind;
    assign dec.dest_reg     = instr[11:7];
    assign dec.src1_reg     = instr[19:15];
    assign dec.src2_reg     = instr[24:20];
    assign dec.imm_value    = imm;
    assign dec.csr_number   = csr;
    assign dec.acquire_flag = aq;
    assign dec.release_flag = rl;

endmodule

// ===== sv/rdec_checker.sv =====
// ----------------------------------------------------------------------------
// rdec_checker
// port-level checks of the rv64 instruction decoder
// ----------------------------------------------------------------------------
`include "rv64_instruction_decoder_core_macros.svh"

module rdec_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [31:0]  s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);
    import rdec_pkg::*;

    `RDEC_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `RDEC_ASSERT_NXT(a_in_hold, aclk, aresetn, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata))
    `RDEC_ASSERT_IMP(a_kind_range, aclk, aresetn, m_tvalid, m_tdata[6:0] <= K_MAX)
    `RDEC_ASSERT_IMP(a_ready_free, aclk, aresetn, !m_tvalid, s_tready)
    `RDEC_ASSERT_IMP(a_csr_kind, aclk, aresetn, m_tvalid && m_tdata[6:0] < K_CSR0, m_tdata[97:86] == 12'd0)

endmodule

bind rv64_instruction_decoder_core rdec_checker u_rdec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
